[hdl/pol_pkg.sv]
`timescale 1ns / 1ps

package pol_pkg;

    // Default list depth.
    localparam int unsigned CAPACITY_DEF = 32;

    // Fixed field widths of the word format.
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LEN_W    = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_POS   = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Operation broadcast along the cell row.
    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2
    } op_t;

endpackage

[hdl/positional_ordered_list_core.sv]
`timescale 1ns / 1ps

// The result of each accepted word is held as pending, then captured into the output register.
// Throughput: one word per cycle while m_ready is high; every operation, including a
// positional insert or delete, is a single parallel shift of the slot row.
// Reset: aresetn (synchronous, active low) empties the list and clears the handshake
// state; the slot contents are not reset, as only occupied slots are ever read.
module positional_ordered_list_core #(
    parameter int unsigned CAPACITY = pol_pkg::CAPACITY_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [pol_pkg::CMD_W-1:0]    s_cmd,
    input  logic signed [pol_pkg::DATA_W-1:0] s_value,
    input  logic [pol_pkg::POS_W-1:0]    s_pos,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pol_pkg::STATUS_W-1:0] m_status,
    output logic [pol_pkg::LEN_W-1:0]    m_length,
    output logic signed [pol_pkg::DATA_W-1:0] m_front_value,
    output logic signed [pol_pkg::DATA_W-1:0] m_back_value
);

    localparam int unsigned IDX_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    // Position and length compared in one bit more than the position field,
    // so that length + 1 cannot wrap.
    localparam int unsigned CMP_W = pol_pkg::POS_W + 1;
    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    // Element count: the only control state of the list itself.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // A word has been applied to the slot row and its result is still to be
    // captured into the output register. Its status is held alongside.
    logic                 pending_reg;
    logic                 pending_next;
    pol_pkg::status_t     pend_status_reg;

    // Output register.
    logic                            m_valid_reg;
    logic                            m_valid_next;
    logic [pol_pkg::STATUS_W-1:0]    m_status_reg;
    logic [pol_pkg::LEN_W-1:0]       m_length_reg;
    logic [pol_pkg::DATA_W-1:0]      m_front_reg;
    logic [pol_pkg::DATA_W-1:0]      m_back_reg;

    logic accept;
    logic load;

    // Decoded operation of the word on the input.
    pol_pkg::status_t dec_status;
    pol_pkg::op_t     dec_op;
    logic [IDX_W-1:0] dec_idx;
    logic [CMP_W-1:0] n_w;
    logic [CMP_W-1:0] pos_w;

    pol_pkg::op_t     row_op;

    logic [pol_pkg::DATA_W-1:0] cell_data [CAPACITY];
    logic [pol_pkg::DATA_W-1:0] cell_last [CAPACITY];
    logic [pol_pkg::DATA_W-1:0] back_or;

    // The result of the pending word is captured as soon as the output
    // register is free or being emptied. A new word may be taken in the same
    // cycle: the capture sees the slot row before that word changes it.
    assign load    = pending_reg && (!m_valid_reg || m_ready);
    assign s_ready = !pending_reg || load;
    assign accept  = s_valid && s_ready;

    assign n_w   = CMP_W'(count_reg);
    assign pos_w = CMP_W'(s_pos);

    // Full and empty checks take priority over the position check. Unused
    // command codes leave the list as it is and report success.
    always_comb begin
        dec_status = pol_pkg::ST_OK;
        dec_op     = pol_pkg::OP_HOLD;
        dec_idx    = '0;
        unique case (s_cmd)
            pol_pkg::CMD_INS_FRONT,
            pol_pkg::CMD_INS_BACK,
            pol_pkg::CMD_INS_POS: begin
                if (count_reg >= CAP_COUNT) begin
                    dec_status = pol_pkg::ST_FULL;
                end else if (s_cmd == pol_pkg::CMD_INS_FRONT) begin
                    dec_op = pol_pkg::OP_INS;
                end else if (s_cmd == pol_pkg::CMD_INS_BACK) begin
                    dec_op  = pol_pkg::OP_INS;
                    dec_idx = IDX_W'(count_reg);
                end else if (pos_w == '0 || pos_w > n_w + CMP_W'(1)) begin
                    dec_status = pol_pkg::ST_RANGE;
                end else begin
                    dec_op  = pol_pkg::OP_INS;
                    dec_idx = IDX_W'(pos_w - CMP_W'(1));
                end
            end
            pol_pkg::CMD_DEL_FRONT,
            pol_pkg::CMD_DEL_BACK,
            pol_pkg::CMD_DEL_POS: begin
                if (count_reg == '0) begin
                    dec_status = pol_pkg::ST_EMPTY;
                end else if (s_cmd == pol_pkg::CMD_DEL_FRONT) begin
                    dec_op = pol_pkg::OP_DEL;
                end else if (s_cmd == pol_pkg::CMD_DEL_BACK) begin
                    dec_op  = pol_pkg::OP_DEL;
                    dec_idx = IDX_W'(n_w - CMP_W'(1));
                end else if (pos_w == '0 || pos_w > n_w) begin
                    dec_status = pol_pkg::ST_RANGE;
                end else begin
                    dec_op  = pol_pkg::OP_DEL;
                    dec_idx = IDX_W'(pos_w - CMP_W'(1));
                end
            end
            default: begin
                dec_status = pol_pkg::ST_OK;
            end
        endcase
    end

    // The row only moves when a word is actually taken.
    assign row_op = accept ? dec_op : pol_pkg::OP_HOLD;

    always_comb begin
        unique case (row_op)
            pol_pkg::OP_INS: count_next = count_reg + CNT_W'(1);
            pol_pkg::OP_DEL: count_next = count_reg - CNT_W'(1);
            default:         count_next = count_reg;
        endcase
    end

    always_comb begin
        pending_next = pending_reg;
        if (accept) begin
            pending_next = 1'b1;
        end else if (load) begin
            pending_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // The row of slots. Slot 0 is the front of the list.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [pol_pkg::DATA_W-1:0] left_w;
        logic [pol_pkg::DATA_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = s_value;
        end else begin : g_inner_l
            assign left_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_inner_r
            assign right_w = cell_data[i+1];
        end

        pol_cell #(
            .CAPACITY (CAPACITY),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .MY_IDX   (i)
        ) u_cell (
            .aclk       (aclk),
            .op         (row_op),
            .idx        (dec_idx),
            .count      (count_reg),
            .value      (s_value),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .last_data  (cell_last[i])
        );
    end

    // Exactly one slot, or none on an empty list, drives its word here.
    always_comb begin
        back_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            back_or = back_or | cell_last[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pending_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_status_reg <= dec_status;
        end
        if (load) begin
            m_status_reg <= pend_status_reg;
            m_length_reg <= pol_pkg::LEN_W'(count_reg);
            m_front_reg  <= (count_reg == '0) ? '0 : cell_data[0];
            m_back_reg   <= back_or;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_length      = m_length_reg;
    assign m_front_value = m_front_reg;
    assign m_back_value  = m_back_reg;

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_COUNT)
        else $error("element count exceeds the list depth");

    a_refused_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && dec_status != pol_pkg::ST_OK) |=> $stable(count_reg))
        else $error("refused word changed the element count");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && dec_op == pol_pkg::OP_INS) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list by one");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_length_reg == '0) |-> (m_front_reg == '0 && m_back_reg == '0))
        else $error("empty list reported a non-zero front or back value");
`endif

endmodule

[hdl/pol_cell.sv]
`timescale 1ns / 1ps

// One list slot. On an insert, slots after the gap take their left neighbour
// and the gap slot takes the new value; on a delete, slots from the removed
// one onwards take their right neighbour.
module pol_cell #(
    parameter int unsigned CAPACITY = pol_pkg::CAPACITY_DEF,
    parameter int unsigned IDX_W    = $clog2(CAPACITY),
    parameter int unsigned CNT_W    = $clog2(CAPACITY + 1),
    parameter int unsigned MY_IDX   = 0
) (
    input  logic                       aclk,
    input  pol_pkg::op_t               op,
    input  logic [IDX_W-1:0]           idx,
    input  logic [CNT_W-1:0]           count,
    input  logic [pol_pkg::DATA_W-1:0] value,
    input  logic [pol_pkg::DATA_W-1:0] left_data,
    input  logic [pol_pkg::DATA_W-1:0] right_data,
    output logic [pol_pkg::DATA_W-1:0] data,
    output logic [pol_pkg::DATA_W-1:0] last_data
);

    localparam logic [IDX_W-1:0] MY       = IDX_W'(MY_IDX);
    localparam logic [CNT_W-1:0] MY_COUNT = CNT_W'(MY_IDX + 1);

    logic [pol_pkg::DATA_W-1:0] data_reg;
    logic [pol_pkg::DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        unique case (op)
            pol_pkg::OP_INS: begin
                if (MY > idx) begin
                    data_next = left_data;
                end else if (MY == idx) begin
                    data_next = value;
                end
            end
            pol_pkg::OP_DEL: begin
                if (MY >= idx) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    // Only the slot that ends the list passes its word on to the back value.
    assign last_data = (count == MY_COUNT) ? data_reg : '0;

endmodule

[tb/sv/tb_positional_ordered_list_core.sv]
`timescale 1ns / 1ps

module tb_positional_ordered_list_core;

    // The list depth matches the default of the block, so the instance keeps its default.
    localparam int CAP = pol_pkg::CAPACITY_DEF;

    // Command codes outside the six real operations; the block must leave the list alone.
    localparam logic [pol_pkg::CMD_W-1:0] CMD_UNUSED_A = 3'd6;
    localparam logic [pol_pkg::CMD_W-1:0] CMD_UNUSED_B = 3'd7;

    // A hard ceiling on the run. The slowest correct run is roughly 920 words, each
    // waiting out the longest sender gap, the longest receiver stall and the block's own
    // delay, plus one long receiver hold-off; this is several times that.
    localparam int unsigned RUN_LIMIT = 200000;

    // How long the receiver refuses words when the input side is to be driven into a stall.
    localparam int unsigned HOLD_CYCLES = 300;

    // Extra cycles are allowed at the end so that any stray result word still shows up
    // before the verdict.
    localparam int unsigned TAIL_CYCLES = 8;

    // One result word as the block should present it.
    typedef struct packed {
        pol_pkg::status_t                   status;
        logic [pol_pkg::LEN_W-1:0]          length;
        logic signed [pol_pkg::DATA_W-1:0]  front;
        logic signed [pol_pkg::DATA_W-1:0]  back;
    } list_result_t;

    logic                               aclk = 1'b0;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic [pol_pkg::CMD_W-1:0]          s_cmd;
    logic signed [pol_pkg::DATA_W-1:0]  s_value;
    logic [pol_pkg::POS_W-1:0]          s_pos;
    logic                               m_valid;
    logic                               m_ready;
    logic [pol_pkg::STATUS_W-1:0]       m_status;
    logic [pol_pkg::LEN_W-1:0]          m_length;
    logic signed [pol_pkg::DATA_W-1:0]  m_front_value;
    logic signed [pol_pkg::DATA_W-1:0]  m_back_value;

    // Shadow copy of the list, updated as each input word is accepted.
    logic signed [pol_pkg::DATA_W-1:0]  shadow_list [CAP];
    int                                 shadow_len;

    // Result words still owed by the block, oldest first.
    list_result_t              owed_results [$];

    int unsigned               fail_count;
    int unsigned               cycle_count;

    // Idling switches for each side, and the request for a long receiver hold-off.
    bit                        sender_idle;
    bit                        recv_idle;
    logic                      hold_req;
    logic                      rx_hold;

    positional_ordered_list_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_value       (s_value),
        .s_pos         (s_pos),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_length      (m_length),
        .m_front_value (m_front_value),
        .m_back_value  (m_back_value)
    );

    // An 8 ns clock, high and low for half a period each.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Applies one operation to the shadow list and returns the word the block should give.
    // The full check on inserts and the empty check on deletes come before any position
    // check, so a full list refuses even a badly placed insert with the full status.
    function automatic list_result_t apply_list_op(
        input logic [pol_pkg::CMD_W-1:0] cmd,
        input logic signed [pol_pkg::DATA_W-1:0] val,
        input logic [pol_pkg::POS_W-1:0] pos);
        list_result_t     res;
        pol_pkg::status_t st;
        int               idx;
        int               i;
        st  = pol_pkg::ST_OK;
        idx = 0;
        case (cmd)
            pol_pkg::CMD_INS_FRONT, pol_pkg::CMD_INS_BACK, pol_pkg::CMD_INS_POS: begin
                if (shadow_len >= CAP) begin
                    st = pol_pkg::ST_FULL;
                end else if (cmd == pol_pkg::CMD_INS_POS &&
                             (pos == 0 || int'(pos) > shadow_len + 1)) begin
                    st = pol_pkg::ST_RANGE;
                end else begin
                    if (cmd == pol_pkg::CMD_INS_BACK) idx = shadow_len;
                    else if (cmd == pol_pkg::CMD_INS_POS) idx = int'(pos) - 1;
                    // Open a gap at the chosen slot by moving the tail one place back.
                    for (i = shadow_len; i > idx; i--) shadow_list[i] = shadow_list[i-1];
                    shadow_list[idx] = val;
                    shadow_len++;
                end
            end
            pol_pkg::CMD_DEL_FRONT, pol_pkg::CMD_DEL_BACK, pol_pkg::CMD_DEL_POS: begin
                if (shadow_len == 0) begin
                    st = pol_pkg::ST_EMPTY;
                end else if (cmd == pol_pkg::CMD_DEL_POS &&
                             (pos == 0 || int'(pos) > shadow_len)) begin
                    st = pol_pkg::ST_RANGE;
                end else begin
                    if (cmd == pol_pkg::CMD_DEL_BACK) idx = shadow_len - 1;
                    else if (cmd == pol_pkg::CMD_DEL_POS) idx = int'(pos) - 1;
                    // Close the gap by pulling the tail one place forward.
                    for (i = idx; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
            end
            default: begin
                // The two spare codes leave everything as it is and report success.
            end
        endcase
        res.status = st;
        res.length = pol_pkg::LEN_W'(shadow_len);
        res.front  = (shadow_len == 0) ? '0 : shadow_list[0];
        res.back   = (shadow_len == 0) ? '0 : shadow_list[shadow_len-1];
        return res;
    endfunction

    // Mostly uniform values, with the extremes and the all-zero and all-one patterns
    // turning up now and then.
    function automatic logic signed [pol_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Offers one input word and returns once it has been accepted. The valid line is
    // lowered only when a gap is drawn, so back-to-back words keep it high throughout.
    task automatic send_word(input logic [pol_pkg::CMD_W-1:0] cmd,
                             input logic signed [pol_pkg::DATA_W-1:0] val,
                             input logic [pol_pkg::POS_W-1:0] pos);
        int gap;
        gap = sender_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_value <= val;
        s_pos   <= pos;
        do @(posedge aclk); while (!s_ready);
        // The word went in at this edge, so the shadow list moves on with it.
        owed_results.push_back(apply_list_op(cmd, val, pos));
    endtask

    // Draws an operation with the given share of inserts. Most positions are in range for
    // the current length; one word in ten takes any position at all, and a few words use
    // the spare command codes.
    task automatic send_random_op(input int unsigned ins_pct);
        logic [pol_pkg::CMD_W-1:0] cmd;
        logic [pol_pkg::POS_W-1:0] pos;
        if ($urandom_range(0, 99) < 4)
            cmd = $urandom_range(0, 1) ? CMD_UNUSED_A : CMD_UNUSED_B;
        else if ($urandom_range(0, 99) < ins_pct)
            cmd = pol_pkg::CMD_W'($urandom_range(pol_pkg::CMD_INS_FRONT,
                                                 pol_pkg::CMD_INS_POS));
        else
            cmd = pol_pkg::CMD_W'($urandom_range(pol_pkg::CMD_DEL_FRONT,
                                                 pol_pkg::CMD_DEL_POS));
        if ($urandom_range(0, 9) == 0)
            pos = pol_pkg::POS_W'($urandom_range(0, 255));
        else if (cmd == pol_pkg::CMD_INS_POS)
            pos = pol_pkg::POS_W'($urandom_range(1, shadow_len + 1));
        else
            pos = (shadow_len == 0) ? pol_pkg::POS_W'(1)
                                    : pol_pkg::POS_W'($urandom_range(1, shadow_len));
        send_word(cmd, pick_value(), pos);
    endtask

    // The sender stops offering and waits until every owed result word has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
    endtask

    // Compares one accepted result word with the oldest owed one.
    task automatic check_result();
        list_result_t want;
        if (owed_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result word: status %0d length %0d front %0d back %0d",
                         m_status, m_length, m_front_value, m_back_value);
            return;
        end
        want = owed_results.pop_front();
        if (m_status !== want.status || m_length !== want.length ||
            m_front_value !== want.front || m_back_value !== want.back) begin
            fail_count++;
            if (fail_count <= 10)
                $display({"result mismatch: expected status %0d length %0d front %0d back %0d,",
                          " got status %0d length %0d front %0d back %0d"},
                         want.status, want.length, want.front, want.back,
                         m_status, m_length, m_front_value, m_back_value);
        end
    endtask

    // Every command and each refusal on a short list, starting from the empty list left
    // by reset and ending empty again.
    task automatic test_directed();
        sender_idle = 1'b1;
        recv_idle   = 1'b1;
        // Deletes on an empty list, including a positional one.
        send_word(pol_pkg::CMD_DEL_FRONT, '0, 8'd0);
        send_word(pol_pkg::CMD_DEL_BACK,  '0, 8'd0);
        send_word(pol_pkg::CMD_DEL_POS,   '0, 8'd1);
        // Positional inserts outside 1 .. length+1 on the empty list.
        send_word(pol_pkg::CMD_INS_POS, 32'sh1234_5678, 8'd0);
        send_word(pol_pkg::CMD_INS_POS, 32'sh1234_5678, 8'd2);
        // Build a five-element list from every kind of insert.
        send_word(pol_pkg::CMD_INS_POS,   32'sh8000_0000, 8'd1);
        send_word(pol_pkg::CMD_INS_FRONT, 32'sh7FFF_FFFF, 8'd0);
        send_word(pol_pkg::CMD_INS_BACK,  -32'sd1,        8'hFF);
        send_word(pol_pkg::CMD_INS_POS,   '0,             8'd4);
        send_word(pol_pkg::CMD_INS_POS,   32'sh5A5A_5A5A, 8'd2);
        send_word(pol_pkg::CMD_INS_POS,   32'sh0F0F_0F0F, 8'd255);
        send_word(pol_pkg::CMD_INS_POS,   32'sh0F0F_0F0F, 8'd7);
        // The spare command codes must not disturb the list.
        send_word(CMD_UNUSED_A, 32'shDEAD_BEEF, 8'd3);
        send_word(CMD_UNUSED_B, 32'shA5A5_A5A5, 8'd0);
        // Positional deletes outside 1 .. length.
        send_word(pol_pkg::CMD_DEL_POS, '0, 8'd0);
        send_word(pol_pkg::CMD_DEL_POS, '0, 8'd6);
        send_word(pol_pkg::CMD_DEL_POS, '0, 8'd255);
        // Take the list apart again from the middle, the end and both sides.
        send_word(pol_pkg::CMD_DEL_POS,   '0, 8'd3);
        send_word(pol_pkg::CMD_DEL_POS,   '0, 8'd4);
        send_word(pol_pkg::CMD_DEL_FRONT, '0, 8'd0);
        send_word(pol_pkg::CMD_DEL_BACK,  '0, 8'd0);
        send_word(pol_pkg::CMD_DEL_POS,   '0, 8'd1);
        // A single element is both front and back.
        send_word(pol_pkg::CMD_INS_BACK, 32'sh8000_0001, 8'd0);
        send_word(pol_pkg::CMD_DEL_BACK, '0, 8'd0);
        wait_drained();
    endtask

    // Fills the list to capacity, hits it with every insert (a bad position included, as
    // the full check wins) and a delete, then empties it and tries deletes on the empty list.
    task automatic test_full_list();
        sender_idle = 1'b1;
        recv_idle   = 1'b1;
        while (shadow_len < CAP) send_random_op(100);
        send_word(pol_pkg::CMD_INS_FRONT, pick_value(), 8'd1);
        send_word(pol_pkg::CMD_INS_BACK,  pick_value(), 8'd1);
        send_word(pol_pkg::CMD_INS_POS,   pick_value(), 8'd0);
        send_word(pol_pkg::CMD_INS_POS,   pick_value(), 8'(CAP));
        send_word(pol_pkg::CMD_INS_POS,   pick_value(), 8'(CAP + 1));
        send_word(pol_pkg::CMD_DEL_POS,   '0,           8'(CAP));
        while (shadow_len > 0) send_random_op(0);
        send_word(pol_pkg::CMD_DEL_POS,   '0, 8'd0);
        send_word(pol_pkg::CMD_DEL_FRONT, '0, 8'd0);
        wait_drained();
    endtask

    // The long random run. The insert share swings between segments so that the length
    // sweeps up and down across the whole range, and the idling pattern changes too:
    // some segments idle on both sides, some on one side only, and some run flat out on both.
    task automatic test_random_ops();
        int seg;
        for (seg = 0; seg < 13; seg++) begin
            sender_idle = (seg % 4 != 3) && (seg % 4 != 2);
            recv_idle   = (seg % 4 != 3) && (seg % 4 != 1);
            repeat (60) send_random_op((seg % 2 == 0) ? 70 : 30);
        end
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering words
    // with no gaps, so the block fills up and has to drop s_ready.
    task automatic test_backpressure();
        sender_idle = 1'b0;
        recv_idle   = 1'b0;
        hold_req <= 1'b1;
        repeat (48) send_random_op(50);
        wait_drained();
    endtask

    // Receiver: takes each result word, checks it, and then draws how long to wait before
    // the next one. A long hold-off from its own process overrides the ready line.
    initial begin : receiver
        int rx_wait;
        rx_wait = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_result();
                rx_wait = recv_idle ? $urandom_range(0, 14) : 0;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_ready <= (rx_wait == 0) && !rx_hold;
        end
    end

    // Counts out the long receiver hold-off once it has been requested.
    initial begin : rx_hold_ctl
        hold_req <= 1'b0;
        rx_hold  <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req <= 1'b0;
                rx_hold  <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold  <= 1'b0;
            end
        end
    end

    // Ends a run that has hung, however that came about.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : run_tests
        fail_count  = 0;
        shadow_len  = 0;
        sender_idle = 1'b1;
        recv_idle   = 1'b1;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_cmd   <= pol_pkg::CMD_INS_FRONT;
        s_value <= '0;
        s_pos   <= '0;
        // Reset is held low from the start and released on an edge; the first word is offered
        // from that same edge onwards.
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_full_list();
        test_random_ops();
        test_backpressure();

        // Everything owed has arrived; further cycles let any stray word surface.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && owed_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[files.f]
hdl/pol_pkg.sv
hdl/pol_cell.sv
hdl/positional_ordered_list_core.sv
tb/sv/tb_positional_ordered_list_core.sv
